// File: design/cnle_pkg.sv
// Shared types and constants for the cutoff neighbor list engine.
// Used by the top level, the distance unit and the port checker.
package cnle_pkg;

  localparam int COORD_W    = 24;
  localparam int CUT_W      = 52;
  localparam int OP_W       = 2;
  localparam int PART_W     = 7;
  localparam int LIST_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int NBR_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int ACC_W      = SQ_W + 1;
  localparam int SUM_W      = SQ_W + 2;
  localparam int FOUND_DEPTH = 63;

  localparam logic [NBR_W-1:0]  MAX_REPORTED   = NBR_W'(FOUND_DEPTH);
  localparam logic [LIST_W-1:0] LIST_COUNT_REQ = 4'd1;
  localparam logic [LIST_W-1:0] LIST_INDEX_REQ = 4'd0;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_BAD_LIST     = 2'd1,
    ST_BAD_PARTICLE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_MODE = 1'b0,
    CFG_CUTOFF_SQ = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAP,
    S_X,
    S_Y,
    S_Z,
    S_CMP,
    S_ERD,
    S_ELOAD,
    S_ONE,
    S_OWAIT
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic    cap_center;
    logic    mul_en;
    axis_t   axis;
    acc_op_t acc_op;
  } dist_ctrl_t;

endpackage

// File: design/cnle_dist_unit.sv
// Shared squared-distance unit: one 25x25 multiplier reused for x, y and z.
// Depends on cnle_pkg for the point and control types.
module cnle_dist_unit (
  input  logic                      clk,
  input  cnle_pkg::dist_ctrl_t      ctrl,
  input  cnle_pkg::point_t          point,
  input  logic [cnle_pkg::CUT_W-1:0] cutoff_sq,
  output logic                      hit
);
  import cnle_pkg::*;

  point_t                   center_r;
  logic signed [COORD_W-1:0] sel_a;
  logic signed [COORD_W-1:0] sel_b;
  logic signed [COORD_W:0]   ext_a;
  logic signed [COORD_W:0]   ext_b;
  logic signed [COORD_W:0]   diff;
  logic signed [2*COORD_W+1:0] prod;
  logic [SQ_W-1:0]           prod_r;
  logic [ACC_W-1:0]          acc_r;
  logic [SUM_W-1:0]          sum;

  always_comb begin
    case (ctrl.axis)
      AXIS_X: begin
        sel_a = point.x;
        sel_b = center_r.x;
      end
      AXIS_Y: begin
        sel_a = point.y;
        sel_b = center_r.y;
      end
      AXIS_Z: begin
        sel_a = point.z;
        sel_b = center_r.z;
      end
      default: begin
        sel_a = point.x;
        sel_b = center_r.x;
      end
    endcase
  end

  assign ext_a = {sel_a[COORD_W-1], sel_a};
  assign ext_b = {sel_b[COORD_W-1], sel_b};
  assign diff  = ext_a - ext_b;
  assign prod  = diff * diff;

  always_ff @(posedge clk) begin
    if (ctrl.cap_center) begin
      center_r <= point;
    end
    if (ctrl.mul_en) begin
      prod_r <= prod[SQ_W-1:0];
    end
    case (ctrl.acc_op)
      ACC_LOAD: acc_r <= ACC_W'(prod_r);
      ACC_ADD:  acc_r <= acc_r + ACC_W'(prod_r);
      default:  acc_r <= acc_r;
    endcase
  end

  assign sum = SUM_W'(acc_r) + SUM_W'(prod_r);
  assign hit = CUT_W'(sum) < cutoff_sq;

endmodule

// File: design/cutoff_neighbor_list_engine_top.sv
// Cutoff neighbor list engine top level: position store, query sequencer, found-index
// buffer and output register. Uses cnle_pkg and cnle_dist_unit. Load, clear and unused
// words keep it idle. A query captures the center (S_CAP), then takes every particle
// through S_X, S_Y, S_Z, S_CMP on the shared multiplier. Results are read in S_ERD
// and loaded in S_ELOAD, the rest once the previous is taken; an error or no hit gives
// one word in S_ONE. Reset clears the count, configuration and sequencer, not the store.
module cutoff_neighbor_list_engine_top #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cnle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cnle_pkg::CUT_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cnle_pkg::OP_W-1:0]        in_op,
  input  logic signed [cnle_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [cnle_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [cnle_pkg::COORD_W-1:0] in_coord_z,
  input  logic [cnle_pkg::PART_W-1:0]      in_particle,
  input  logic [cnle_pkg::LIST_W-1:0]      in_list_count,
  input  logic [cnle_pkg::LIST_W-1:0]      in_list_index,
  input  logic [cnle_pkg::CUT_W-1:0]       in_req_cutoff_sq,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cnle_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_has_neighbor,
  output logic [cnle_pkg::NBR_W-1:0]       out_neighbor_index,
  output logic [cnle_pkg::NBR_W-1:0]       out_neighbor_count,
  output logic                             out_last
);
  import cnle_pkg::*;

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int PW = (CW > PART_W) ? CW : PART_W;

  state_t state_r, state_nxt;

  logic             half_mode_r;
  logic [CUT_W-1:0] cutoff_sq_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    p_r, p_nxt;
  logic [AW-1:0]    j_r, j_nxt;
  logic [NBR_W-1:0] n_r, n_nxt;
  logic [NBR_W-1:0] k_r, k_nxt;
  status_t          st_r, st_nxt;

  point_t           store_mem [MAX_PARTICLES];
  point_t           store_rd_r;
  logic             store_we;
  logic             store_re;
  logic [AW-1:0]    store_raddr;
  point_t           store_wdata;

  logic [NBR_W-1:0] found_mem [FOUND_DEPTH];
  logic [NBR_W-1:0] found_rd_r;
  logic             found_we;
  logic             found_re;

  dist_ctrl_t       dctrl;
  logic             hit;

  logic             accept;
  logic             bad_list;
  logic             bad_part;
  logic             keep;
  logic             scan_done;
  logic [CW-1:0]    j_inc;
  logic [AW-1:0]    j_next_addr;

  logic             out_load;
  status_t          out_status_d;
  logic             out_has_d;
  logic [NBR_W-1:0] out_idx_d;
  logic [NBR_W-1:0] out_cnt_d;
  logic             out_last_d;

  logic             out_valid_r;
  status_t          out_status_r;
  logic             out_has_r;
  logic [NBR_W-1:0] out_idx_r;
  logic [NBR_W-1:0] out_cnt_r;
  logic             out_last_r;

  assign accept      = in_valid && in_ready;
  assign bad_list    = (in_list_count != LIST_COUNT_REQ) ||
                       (in_list_index != LIST_INDEX_REQ) ||
                       (in_req_cutoff_sq > cutoff_sq_r);
  assign bad_part    = PW'(in_particle) >= PW'(count_r);
  assign keep        = half_mode_r ? (j_r > p_r) : (j_r != p_r);
  assign j_inc       = CW'(j_r) + CW'(1'b1);
  assign scan_done   = j_inc == count_r;
  assign j_next_addr = j_r + AW'(1'b1);
  assign store_wdata = '{x: in_coord_x, y: in_coord_y, z: in_coord_z};
  assign store_we    = accept && (in_op == OP_LOAD) && (count_r != CW'(MAX_PARTICLES));

  cnle_dist_unit u_dist (
    .clk       (clk),
    .ctrl      (dctrl),
    .point     (store_rd_r),
    .cutoff_sq (cutoff_sq_r),
    .hit       (hit)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_op == OP_QUERY)) begin
          state_nxt = (bad_list || bad_part) ? S_ONE : S_CAP;
        end
      end
      S_CAP: state_nxt = S_X;
      S_X:   state_nxt = S_Y;
      S_Y:   state_nxt = S_Z;
      S_Z:   state_nxt = S_CMP;
      S_CMP: begin
        if (!scan_done) begin
          state_nxt = S_X;
        end else if (n_nxt == '0) begin
          state_nxt = S_ONE;
        end else begin
          state_nxt = S_ERD;
        end
      end
      S_ERD:   state_nxt = S_ELOAD;
      S_ELOAD: state_nxt = S_OWAIT;
      S_ONE:   state_nxt = S_OWAIT;
      S_OWAIT: begin
        if (out_ready) begin
          state_nxt = out_last_r ? S_IDLE : S_ERD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready     = 1'b0;
    store_re     = 1'b0;
    store_raddr  = j_r;
    found_we     = 1'b0;
    found_re     = 1'b0;
    out_load     = 1'b0;
    out_status_d = st_r;
    out_has_d    = 1'b0;
    out_idx_d    = '0;
    out_cnt_d    = '0;
    out_last_d   = 1'b1;
    dctrl.cap_center = 1'b0;
    dctrl.mul_en     = 1'b0;
    dctrl.axis       = AXIS_X;
    dctrl.acc_op     = ACC_HOLD;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        store_re    = in_valid;
        store_raddr = AW'(in_particle);
      end
      S_CAP: begin
        dctrl.cap_center = 1'b1;
        store_re         = 1'b1;
      end
      S_X: begin
        dctrl.mul_en = 1'b1;
        dctrl.axis   = AXIS_X;
      end
      S_Y: begin
        dctrl.mul_en = 1'b1;
        dctrl.axis   = AXIS_Y;
        dctrl.acc_op = ACC_LOAD;
      end
      S_Z: begin
        dctrl.mul_en = 1'b1;
        dctrl.axis   = AXIS_Z;
        dctrl.acc_op = ACC_ADD;
      end
      S_CMP: begin
        found_we    = keep && hit && (n_r != MAX_REPORTED);
        store_re    = !scan_done;
        store_raddr = j_next_addr;
      end
      S_ERD: begin
        found_re = 1'b1;
      end
      S_ELOAD: begin
        out_load     = 1'b1;
        out_status_d = ST_OK;
        out_has_d    = 1'b1;
        out_idx_d    = found_rd_r;
        out_cnt_d    = n_r;
        out_last_d   = (k_r + NBR_W'(1'b1)) == n_r;
      end
      S_ONE: begin
        out_load = 1'b1;
      end
      S_OWAIT: begin
      end
      default: begin
      end
    endcase
  end

  // Counters and query bookkeeping.
  always_comb begin
    count_nxt = count_r;
    p_nxt     = p_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    st_nxt    = st_r;
    if (accept) begin
      unique case (in_op)
        OP_LOAD: begin
          if (store_we) begin
            count_nxt = count_r + CW'(1'b1);
          end
        end
        OP_CLEAR: count_nxt = '0;
        OP_QUERY: begin
          p_nxt = AW'(in_particle);
          j_nxt = '0;
          n_nxt = '0;
          k_nxt = '0;
          if (bad_list) begin
            st_nxt = ST_BAD_LIST;
          end else if (bad_part) begin
            st_nxt = ST_BAD_PARTICLE;
          end else begin
            st_nxt = ST_OK;
          end
        end
        default: begin
        end
      endcase
    end
    if (state_r == S_CMP) begin
      j_nxt = j_next_addr;
      if (found_we) begin
        n_nxt = n_r + NBR_W'(1'b1);
      end
    end
    if ((state_r == S_OWAIT) && out_ready) begin
      k_nxt = k_r + NBR_W'(1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      j_r         <= '0;
      n_r         <= '0;
      k_r         <= '0;
      st_r        <= ST_OK;
      half_mode_r <= 1'b0;
      cutoff_sq_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      st_r    <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HALF_MODE: half_mode_r <= cfg_wdata[0];
          CFG_CUTOFF_SQ: cutoff_sq_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (out_load) begin
      out_status_r <= out_status_d;
      out_has_r    <= out_has_d;
      out_idx_r    <= out_idx_d;
      out_cnt_r    <= out_cnt_d;
      out_last_r   <= out_last_d;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[count_r[AW-1:0]] <= store_wdata;
    end
    if (store_re) begin
      store_rd_r <= store_mem[store_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (found_we) begin
      found_mem[n_r] <= NBR_W'(j_r);
    end
    if (found_re) begin
      found_rd_r <= found_mem[k_r];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_has_neighbor   = out_has_r;
  assign out_neighbor_index = out_idx_r;
  assign out_neighbor_count = out_cnt_r;
  assign out_last           = out_last_r;

endmodule

// File: design/cnle_checker.sv
// Port-level checker for the cutoff neighbor list engine, bound to the top.
// Depends on cnle_pkg for widths and status codes.
module cnle_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cnle_pkg::STATUS_W-1:0] out_status,
  input logic                          out_has_neighbor,
  input logic [cnle_pkg::NBR_W-1:0]    out_neighbor_index,
  input logic [cnle_pkg::NBR_W-1:0]    out_neighbor_count,
  input logic                          out_last
);
  import cnle_pkg::*;

  // A query's results are all delivered before a new word is taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result word is pending");

  // A real neighbor only appears in a successful query with a nonzero count.
  a_neighbor_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_neighbor |-> (out_status == ST_OK) && (out_neighbor_count != '0))
    else $error("neighbor word with bad status or zero count");

  // Words without a neighbor are single, final and empty.
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_neighbor |->
      out_last && (out_neighbor_index == '0) && (out_neighbor_count == '0))
    else $error("empty result word is malformed");

  // After a non-final word is taken, more words follow before new input.
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("input taken before the last result word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_has_neighbor) && $stable(out_neighbor_index) &&
      $stable(out_neighbor_count) && $stable(out_last))
    else $error("stalled result word changed");

endmodule

bind cutoff_neighbor_list_engine_top cnle_checker u_cnle_checker (.*);
